/* hdl/wma_pkg.sv */
// Package for the windowed moving average unit: request and result payload
// types, field widths and command / register codes. No dependencies.
package wma_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int MEAN_BITS   = 48;

    // APB register map: byte address width and register indexes.
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [APB_ADDR_W-3:0] REG_WINDOW_SIZE = '0;

    localparam int WINDOW_RESET = 16;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [MEAN_BITS-1:0] mean;
        logic                        mean_valid;
        logic                        window_full;
    } out_item_t;

endpackage

/* hdl/windowed_moving_average_unit.sv */
// Top level of the windowed moving average unit: APB window size register,
// front end, job queue and divider back end. Depends on wma_pkg and the wma_ modules.
//
// Usage. Requests arrive on the s_ channel (valid/ready) as a command and a
// signed sample. A sample request stores the sample in a ring of the last
// window_size samples and updates the running sum; a clear request empties
// the window. Every request yields exactly one result on the m_ channel:
// the mean of the stored samples with FRAC_BITS fraction bits (truncated
// toward zero), a mean-valid flag and a window-full flag.
// The window size register sits at byte address 0 of the APB port; write
// it only while the unit is idle and follow the change with a clear.
// Rate: a sample request passes the front end through F_IDLE and F_UPD,
// a clear through F_IDLE alone. The back end divides the running sum by
// the fill count with a restoring divider that produces one quotient bit
// per cycle; that divider sets the sustained rate. The back end takes the
// next job only after the previous result is in the output register.
// Reset (aresetn low, synchronous) empties the window, zeroes the sum,
// fill count and write index and sets the window size to 16. The sample
// ring holds no reset value; entries are read only after being written.
// When the receiver stalls, the finished result waits in the output
// register while the front end keeps taking requests until the two-entry
// job queue fills, at which point s_ready drops.
module windowed_moving_average_unit import wma_pkg::*; #(
    parameter int MAX_WINDOW = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Derived widths: ring index, window register, running sum and one
    // queued job (clear flag, sum, count, full flag).
    localparam int IW    = $clog2(MAX_WINDOW);
    localparam int CW    = IW + 1;
    localparam int SUM_W = SAMPLE_BITS + IW;
    localparam int JOB_W = SUM_W + CW + 2;

    // The reset window never exceeds the largest window the ring holds.
    localparam int WIN_INIT = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    logic [CW-1:0]    window_size_reg;
    logic             reg_hit;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    logic [JOB_W-1:0] push_data;
    logic [JOB_W-1:0] pop_data;

    // The APB port never inserts wait states. Only the window size register
    // exists; the upper word reads as zero and ignores writes.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE);
    assign prdata  = reg_hit ? APB_DATA_W'(window_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= CW'(WIN_INIT);
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            window_size_reg <= pwdata[CW-1:0];
        end
    end

    // The front end owns the ring and all window bookkeeping; each request
    // becomes one job that carries everything the divider needs.
    wma_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .IW         (IW),
        .CW         (CW),
        .SUM_W      (SUM_W),
        .JOB_W      (JOB_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .window_size (window_size_reg),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    // The queue lets the front end run ahead while the divider is busy or
    // the output is stalled.
    wma_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end turns each job into one result and holds it in the
    // output register until the receiver takes it.
    wma_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .FRAC_BITS  (FRAC_BITS),
        .IW         (IW),
        .CW         (CW),
        .SUM_W      (SUM_W),
        .JOB_W      (JOB_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* hdl/wma_front.sv */
// Front end of the moving average unit: accepts requests, keeps the sample
// ring, running sum, fill count and write index, and posts jobs to the queue.
// Depends on wma_pkg.
module wma_front import wma_pkg::*; #(
    parameter int MAX_WINDOW = 1024,
    parameter int IW         = $clog2(MAX_WINDOW),
    parameter int CW         = IW + 1,
    parameter int SUM_W      = SAMPLE_BITS + IW,
    parameter int JOB_W      = SUM_W + CW + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    input  logic [CW-1:0]    window_size,
    input  logic             q_full,
    output logic             push,
    output logic [JOB_W-1:0] push_data
);

    typedef struct packed {
        logic             clear;
        logic [SUM_W-1:0] sum;
        logic [CW-1:0]    count;
        logic             full;
    } job_t;

    typedef enum logic {F_IDLE, F_UPD} state_t;

    state_t                  state_reg;
    logic [IW-1:0]           write_index_reg;
    logic [IW-1:0]           idx_reg;
    logic [CW-1:0]           fill_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  old_reg;
    logic [SAMPLE_BITS-1:0]  ring [MAX_WINDOW];

    logic                    accept;
    logic [CW-1:0]           w_eff;
    logic [IW-1:0]           idx_eff;
    logic                    was_full;
    logic signed [SAMPLE_BITS:0] delta;
    logic [SUM_W-1:0]        sum_next;
    logic [CW-1:0]           fill_next;
    logic [CW-1:0]           idx_inc;
    logic [IW-1:0]           write_index_next;
    job_t                    job;

    assign s_ready = (state_reg == F_IDLE) && !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (window_size == '0) begin
            w_eff = CW'(1);
        end else if (window_size > CW'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = window_size;
        end
    end

    // An index left beyond a shrunken window restarts at the first entry.
    assign idx_eff = (CW'(write_index_reg) >= w_eff) ? '0 : write_index_reg;

    assign was_full  = (fill_reg >= w_eff);
    assign delta     = $signed({sample_reg[SAMPLE_BITS-1], sample_reg})
                     - (was_full ? $signed({old_reg[SAMPLE_BITS-1], old_reg})
                                 : $signed((SAMPLE_BITS+1)'(0)));
    assign sum_next  = sum_reg + SUM_W'(delta);
    assign fill_next = was_full ? fill_reg : fill_reg + CW'(1);
    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign write_index_next = (idx_inc >= w_eff) ? '0 : idx_inc[IW-1:0];

    always_comb begin
        job  = '0;
        push = 1'b0;
        if (state_reg == F_IDLE) begin
            if (accept && s_data.command == CMD_CLEAR) begin
                job.clear = 1'b1;
                push      = 1'b1;
            end
        end else begin
            job.sum   = sum_next;
            job.count = fill_next;
            job.full  = (fill_next >= w_eff);
            push      = 1'b1;
        end
    end
    assign push_data = job;

    always_ff @(posedge aclk) begin
        if (state_reg == F_UPD) begin
            ring[idx_reg] <= sample_reg;
        end
        if (accept) begin
            old_reg <= ring[idx_eff];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_IDLE;
            write_index_reg <= '0;
            fill_reg        <= '0;
            sum_reg         <= '0;
            idx_reg         <= '0;
            sample_reg      <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        if (s_data.command == CMD_CLEAR) begin
                            write_index_reg <= '0;
                            fill_reg        <= '0;
                            sum_reg         <= '0;
                        end else begin
                            idx_reg    <= idx_eff;
                            sample_reg <= s_data.sample;
                            state_reg  <= F_UPD;
                        end
                    end
                end
                F_UPD: begin
                    sum_reg         <= sum_next;
                    fill_reg        <= fill_next;
                    write_index_reg <= write_index_next;
                    state_reg       <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

/* hdl/wma_queue.sv */
// Two-entry job queue between the front end and the divider back end.
// Depends on wma_pkg only for the shared import convention.
module wma_queue import wma_pkg::*; #(
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            priority if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end else begin
                count_reg <= count_reg;
            end
        end
    end

endmodule

/* hdl/wma_back.sv */
// Back end of the moving average unit: a restoring divider, one quotient bit
// per cycle, followed by saturation, sign and the result register.
// Depends on wma_pkg.
module wma_back import wma_pkg::*; #(
    parameter int MAX_WINDOW = 1024,
    parameter int FRAC_BITS  = 16,
    parameter int IW         = $clog2(MAX_WINDOW),
    parameter int CW         = IW + 1,
    parameter int SUM_W      = SAMPLE_BITS + IW,
    parameter int JOB_W      = SUM_W + CW + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  logic [JOB_W-1:0] pop_data,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int DW  = SUM_W + FRAC_BITS;
    localparam int QX  = (DW > MEAN_BITS) ? DW : MEAN_BITS + 1;
    localparam int NW  = $clog2(DW + 1);

    typedef struct packed {
        logic             clear;
        logic [SUM_W-1:0] sum;
        logic [CW-1:0]    count;
        logic             full;
    } job_t;

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_FIN} state_t;

    localparam logic [QX-1:0] LIM_POS = (QX'(1) << (MEAN_BITS - 1)) - QX'(1);
    localparam logic [QX-1:0] LIM_NEG = QX'(1) << (MEAN_BITS - 1);

    state_t           state_reg;
    logic [DW-1:0]    div_reg;
    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    den_reg;
    logic [NW-1:0]    step_reg;
    logic             neg_reg;
    logic             full_reg;
    logic             clear_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    job_t             job;
    logic [SUM_W-1:0] mag;
    logic [CW:0]      trial;
    logic             qbit;
    logic [QX-1:0]    q_ext;
    logic [QX-1:0]    q_sat;
    logic             out_free;
    out_item_t        result;

    assign job   = pop_data;
    assign pop   = (state_reg == B_IDLE) && !q_empty;
    assign mag   = job.sum[SUM_W-1] ? (~job.sum + SUM_W'(1)) : job.sum;
    assign trial = {rem_reg, div_reg[DW-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb begin
        q_ext = QX'(div_reg);
        if (neg_reg) begin
            q_sat = (q_ext > LIM_NEG) ? LIM_NEG : q_ext;
        end else begin
            q_sat = (q_ext > LIM_POS) ? LIM_POS : q_ext;
        end
        result = '0;
        if (!clear_reg) begin
            result.mean        = neg_reg ? -q_sat[MEAN_BITS-1:0] : q_sat[MEAN_BITS-1:0];
            result.mean_valid  = 1'b1;
            result.window_full = full_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            div_reg     <= '0;
            rem_reg     <= '0;
            den_reg     <= '0;
            step_reg    <= '0;
            neg_reg     <= 1'b0;
            full_reg    <= 1'b0;
            clear_reg   <= 1'b0;
        end else begin
            // In B_FIN a taken result is replaced by the next one below.
            if (m_valid_reg && m_ready && state_reg != B_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        clear_reg <= job.clear;
                        neg_reg   <= job.sum[SUM_W-1];
                        full_reg  <= job.full;
                        den_reg   <= job.count;
                        div_reg   <= DW'(mag) << FRAC_BITS;
                        rem_reg   <= '0;
                        step_reg  <= NW'(DW);
                        state_reg <= job.clear ? B_FIN : B_DIV;
                    end
                end
                B_DIV: begin
                    rem_reg  <= qbit ? CW'(trial - {1'b0, den_reg}) : trial[CW-1:0];
                    div_reg  <= {div_reg[DW-2:0], qbit};
                    step_reg <= step_reg - NW'(1);
                    if (step_reg == NW'(1)) begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN: begin
                    if (out_free) begin
                        m_data_reg  <= result;
                        m_valid_reg <= 1'b1;
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

/* tb/sv/tb_windowed_moving_average_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for windowed_moving_average_unit: a directed table,
// then random segments, each result checked against an in-bench average model.
// Depends on wma_pkg and the RTL of the unit only.
module tb_windowed_moving_average_unit;
    import wma_pkg::*;

    localparam int MAX_WINDOW      = 1024;
    localparam int FRAC_BITS       = 16;
    localparam int SUM_W           = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int ITEMS_PER_PHASE = 410;
    localparam int PRINT_LIMIT     = 40;

    // One row of the directed table. When cfg is set, the window register is
    // written (with the unit idle) before the request goes out. When lit is
    // set, the typed-in result is expected instead of the model's.
    typedef struct {
        bit        cfg;
        logic [31:0] wdata;
        in_item_t  req;
        bit        lit;
        out_item_t want;
    } step_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Model state: the sample ring, the running sum at its wrapping width,
    // the fill count, the write index and the raw window register.
    logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    bit                     ring_seen [MAX_WINDOW];
    logic [SUM_W-1:0]       acc_sum   = '0;
    int unsigned            fill_cnt  = 0;
    int unsigned            wr_idx    = 0;
    logic [10:0]            win_reg   = 11'(WINDOW_RESET);

    out_item_t pending_averages [$];
    out_item_t due;
    step_t     directed_steps [];
    int        mismatches    = 0;
    int        sent_count    = 0;
    int        send_idle_pct = 21;
    int        recv_idle_pct = 71;

    windowed_moving_average_unit #(
        .MAX_WINDOW(MAX_WINDOW),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The run ends here if something hangs; the budget is many times the
    // slowest correct run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // A register value of zero acts as a window of one, and anything above
    // the ring depth acts as the full ring.
    function automatic int unsigned active_window(logic [10:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_WINDOW)
            return MAX_WINDOW;
        return raw;
    endfunction

    // Signed sum over count with FRAC_BITS fraction bits, truncated toward
    // zero, clamped to the 48-bit range.
    function automatic logic [MEAN_BITS-1:0] truncated_mean(logic [SUM_W-1:0] total,
                                                            int unsigned count);
        logic [63:0] wide, mag, quo, rem, limit, res;
        bit          neg;
        wide  = {{(64-SUM_W){total[SUM_W-1]}}, total};
        neg   = total[SUM_W-1];
        mag   = neg ? -wide : wide;
        quo   = mag / count;
        rem   = mag % count;
        limit = (64'd1 << (MEAN_BITS - 1)) - (neg ? 64'd0 : 64'd1);
        if (quo > (limit >> FRAC_BITS)) begin
            res = limit;
        end else begin
            res = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / count);
            if (res > limit)
                res = limit;
        end
        if (neg)
            res = -res;
        return res[MEAN_BITS-1:0];
    endfunction

    // Applies one accepted request to the model and returns the result the
    // unit owes for it.
    function automatic out_item_t advance_average(in_item_t req);
        int unsigned      w;
        logic [SUM_W-1:0] incoming, evicted;
        out_item_t        res;
        w   = active_window(win_reg);
        res = '0;
        if (req.command == CMD_CLEAR) begin
            fill_cnt = 0;
            acc_sum  = '0;
            wr_idx   = 0;
            return res;
        end
        incoming = {{(SUM_W-SAMPLE_BITS){req.sample[SAMPLE_BITS-1]}}, req.sample};
        // A write index left beyond a shrunken window starts over at zero.
        if (wr_idx >= w)
            wr_idx = 0;
        acc_sum = acc_sum + incoming;
        if (fill_cnt >= w) begin
            evicted = {{(SUM_W-SAMPLE_BITS){ring_mem[wr_idx][SAMPLE_BITS-1]}},
                       ring_mem[wr_idx]};
            acc_sum = acc_sum - evicted;
        end else begin
            fill_cnt++;
        end
        ring_mem[wr_idx]  = req.sample;
        ring_seen[wr_idx] = 1'b1;
        wr_idx++;
        if (wr_idx >= w)
            wr_idx = 0;
        res.mean        = truncated_mean(acc_sum, fill_cnt);
        res.mean_valid  = 1'b1;
        res.window_full = (fill_cnt >= w);
        return res;
    endfunction

    function automatic step_t mk(bit cfg, logic [31:0] wdata, logic cmd,
                                 logic signed [31:0] smp, bit lit,
                                 logic signed [47:0] mean, logic mv, logic wf);
        step_t row;
        row.cfg              = cfg;
        row.wdata            = wdata;
        row.req.command      = cmd;
        row.req.sample       = smp;
        row.lit              = lit;
        row.want.mean        = mean;
        row.want.mean_valid  = mv;
        row.want.window_full = wf;
        return row;
    endfunction

    // Random words half the time, otherwise small values or the corner values.
    function automatic logic signed [31:0] random_sample();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(2000) - 1000;
            2: begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Receiver: stalls on a random share of cycles, set per phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every accepted result is held against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_averages.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data), 64'd0);
            end else begin
                due = pending_averages.pop_front();
                if (m_data.mean !== due.mean)
                    report_mismatch("mean", 64'(m_data.mean), 64'(due.mean));
                if (m_data.mean_valid !== due.mean_valid)
                    report_mismatch("mean_valid", 64'(m_data.mean_valid),
                                    64'(due.mean_valid));
                if (m_data.window_full !== due.window_full)
                    report_mismatch("window_full", 64'(m_data.window_full),
                                    64'(due.window_full));
            end
        end
    end

    // Offers one request, holding valid and payload until accepted, then
    // records what the unit must answer. Random gaps come before the offer
    // so that valid never drops while a request is waiting.
    task automatic send_request(in_item_t req, bit lit, out_item_t typed_in);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = advance_average(req);
        pending_averages = {pending_averages, lit ? typed_in : predicted};
        sent_count++;
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge aclk);
    endtask

    task automatic read_window(logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== want)
            report_mismatch("window_size readback", 64'(prdata), 64'(want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes the window register, then reads it back. Only the low 11 bits
    // of the write data are kept.
    task automatic program_window(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        win_reg = value[10:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        read_window({21'd0, value[10:0]});
    endtask

    // One random segment: a new window size, normally followed by a clear,
    // then a run of samples with an occasional clear thrown in.
    task automatic run_segment();
        int unsigned pick, win, span, n;
        logic [31:0] junk;
        bit          keep;
        in_item_t    req;
        drain_results();
        pick = $urandom_range(99);
        if (pick < 55)
            win = $urandom_range(1, 8);
        else if (pick < 85)
            win = $urandom_range(9, 40);
        else if (pick < 92)
            win = $urandom_range(41, 120);
        else if (pick < 95)
            win = 0;
        else if (pick < 97)
            win = MAX_WINDOW;
        else
            win = $urandom_range(MAX_WINDOW + 1, 2047);
        junk = $urandom_range(1) ? $urandom : 32'd0;
        program_window({junk[31:11], win[10:0]});
        span = active_window(win[10:0]);
        // Now and then the clear is skipped, but only when every ring entry
        // the new window can reach already holds a sample.
        keep = ($urandom_range(9) == 0);
        for (int i = 0; i < span; i++)
            if (!ring_seen[i])
                keep = 1'b0;
        if (!keep) begin
            req.command = CMD_CLEAR;
            req.sample  = random_sample();
            send_request(req, 1'b0, '0);
        end
        // Large windows get short runs; the rest may run past full and wrap.
        n = (span <= 120) ? $urandom_range(1, 2 * span + 5) : $urandom_range(1, 40);
        repeat (n) begin
            req.command = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_SAMPLE;
            req.sample  = random_sample();
            send_request(req, 1'b0, '0);
        end
    endtask

    initial begin
        int phase_end;

        // Directed table. The window is 16 out of reset until row 6.
        directed_steps = '{
            // Clear straight after reset: zero mean, both flags low.
            mk(0, 0, CMD_CLEAR, 0, 1, 48'sh0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, 5, 1, 48'sh0000_0005_0000, 1'b1, 1'b0),
            mk(0, 0, CMD_SAMPLE, -7, 0, '0, 1'b0, 1'b0),
            mk(0, 0, CMD_CLEAR, 0, 1, 48'sh0, 1'b0, 1'b0),
            // Most negative sample alone gives the most negative mean.
            mk(0, 0, CMD_SAMPLE, 32'sh8000_0000, 1, 48'sh8000_0000_0000, 1'b1, 1'b0),
            mk(0, 0, CMD_SAMPLE, 32'sh7FFF_FFFF, 0, '0, 1'b0, 1'b0),
            // Window shrunk to one without a clear: the write index wraps.
            mk(1, 1, CMD_SAMPLE, 3, 0, '0, 1'b0, 1'b0),
            mk(0, 0, CMD_CLEAR, 0, 1, 48'sh0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, 32'sh7FFF_FFFF, 1, 48'sh7FFF_FFFF_0000, 1'b1, 1'b1),
            mk(0, 0, CMD_SAMPLE, 32'sh8000_0000, 1, 48'sh8000_0000_0000, 1'b1, 1'b1),
            // A window size of zero acts as one.
            mk(1, 0, CMD_CLEAR, 0, 1, 48'sh0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, 9, 1, 48'sh0000_0009_0000, 1'b1, 1'b1),
            // The largest register value saturates to the ring depth.
            mk(1, 2047, CMD_CLEAR, 0, 1, 48'sh0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, -1, 1, 48'shFFFF_FFFF_0000, 1'b1, 1'b0),
            // Upper write data bits are dropped: this sets a window of three.
            mk(1, 32'hFFFF_F803, CMD_CLEAR, 0, 1, 48'sh0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, 1, 1, 48'sh0000_0001_0000, 1'b1, 1'b0),
            mk(0, 0, CMD_SAMPLE, 2, 0, '0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, -4, 0, '0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, 100, 0, '0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, 32'sh7FFF_FFFF, 0, '0, 1'b0, 1'b0),
            mk(0, 0, CMD_SAMPLE, 32'sh7FFF_FFFF, 0, '0, 1'b0, 1'b0),
            // Ring now holds only the largest sample.
            mk(0, 0, CMD_SAMPLE, 32'sh7FFF_FFFF, 1, 48'sh7FFF_FFFF_0000, 1'b1, 1'b1)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_window(WINDOW_RESET);

        foreach (directed_steps[k]) begin
            if (directed_steps[k].cfg) begin
                drain_results();
                program_window(directed_steps[k].wdata);
            end
            send_request(directed_steps[k].req, directed_steps[k].lit,
                         directed_steps[k].want);
        end

        // Random part in three idling phases: slow receiver, slow sender,
        // then both at full speed.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 21 : 0;
            phase_end     = sent_count + ITEMS_PER_PHASE;
            while (sent_count < phase_end)
                run_segment();
        end

        // Wait for the last results, then a little longer to catch strays.
        drain_results();
        repeat (80) @(posedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
